### hw/rtl/tpmq_pkg.sv
package tpmq_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = 11;
    localparam int NADDR_BITS  = 10;
    localparam int DEPTH_BITS  = 10;
    localparam int TADDR_BITS  = 11;
    localparam int TIDX_BITS   = 12;
    localparam int WEIGHT_BITS = 20;
    localparam int NENT_BITS   = 3 * NODE_BITS + DEPTH_BITS;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // controller to datapath, one-hot-ish strobes per cycle
    typedef struct packed {
        logic latch;
        logic node_wr;
        logic leaf_wr;
        logic sib_rd;
        logic up_wr;
        logic clr_wr;
        logic q_init;
        logic rd_a;
        logic rd_b;
        logic cap_a;
        logic cap_b;
        logic rd_ha;
        logic rd_hb;
        logic cap_ha;
        logic step;
        logic fin;
        logic r_init;
        logic r_rd_a;
        logic r_rd_b;
        logic r_acc;
        logic r_shift;
        logic out_load;
    } tpmq_cmd_t;

    typedef struct packed {
        op_t  op;
        logic node_ok;
        logic pos_ok;
        logic idx_gt1;
        logic same_chain;
        logic r_empty;
        logic r_lt;
        logic ta_odd;
        logic tb_odd;
        logic clr_last;
        logic out_busy;
    } tpmq_stat_t;

    function automatic logic slot_ok(input logic [NODE_BITS-1:0] n);
        slot_ok = (n >= NODE_BITS'(1)) && (n <= NODE_BITS'(MAX_NODES));
    endfunction

endpackage

### hw/rtl/tpmq_ctrl.sv
module tpmq_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tpmq_pkg::tpmq_stat_t  stat,
    output tpmq_pkg::tpmq_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_DISP, S_UP0, S_UP1,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5,
        S_RINIT, S_RLOOP, S_RACA, S_RB0, S_RACB, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   ret_fin_reg, ret_fin_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        ret_fin_next = ret_fin_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.op)
                    tpmq_pkg::OP_LOAD:
                    begin
                        cmd.node_wr = stat.node_ok;
                        state_next  = S_IDLE;
                    end
                    tpmq_pkg::OP_WEIGHT:
                    begin
                        cmd.leaf_wr = stat.pos_ok;
                        state_next  = stat.pos_ok ? S_UP0 : S_IDLE;
                    end
                    tpmq_pkg::OP_QUERY:
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_Q0;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_UP0:
            begin
                if (stat.idx_gt1)
                begin
                    cmd.sib_rd = 1'b1;
                    state_next = S_UP1;
                end
                else
                    state_next = S_IDLE;
            end
            S_UP1:
            begin
                cmd.up_wr  = 1'b1;
                state_next = S_UP0;
            end
            S_Q0:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_Q1;
            end
            S_Q1:
            begin
                cmd.cap_a  = 1'b1;
                cmd.rd_b   = 1'b1;
                state_next = S_Q2;
            end
            S_Q2:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_Q3;
            end
            S_Q3:
            begin
                if (stat.same_chain)
                begin
                    cmd.fin      = 1'b1;
                    ret_fin_next = 1'b1;
                    state_next   = S_RINIT;
                end
                else
                begin
                    cmd.rd_ha  = 1'b1;
                    state_next = S_Q4;
                end
            end
            S_Q4:
            begin
                cmd.cap_ha = 1'b1;
                cmd.rd_hb  = 1'b1;
                state_next = S_Q5;
            end
            S_Q5:
            begin
                cmd.step     = 1'b1;
                ret_fin_next = 1'b0;
                state_next   = S_RINIT;
            end
            S_RINIT:
            begin
                if (stat.r_empty)
                    state_next = ret_fin_reg ? S_OUT : S_Q0;
                else
                begin
                    cmd.r_init = 1'b1;
                    state_next = S_RLOOP;
                end
            end
            S_RLOOP:
            begin
                if (!stat.r_lt)
                    state_next = ret_fin_reg ? S_OUT : S_Q0;
                else if (stat.ta_odd)
                begin
                    cmd.r_rd_a = 1'b1;
                    state_next = S_RACA;
                end
                else
                    state_next = S_RB0;
            end
            S_RACA:
            begin
                cmd.r_acc  = 1'b1;
                state_next = S_RB0;
            end
            S_RB0:
            begin
                if (stat.tb_odd)
                begin
                    cmd.r_rd_b = 1'b1;
                    state_next = S_RACB;
                end
                else
                begin
                    cmd.r_shift = 1'b1;
                    state_next  = S_RLOOP;
                end
            end
            S_RACB:
            begin
                cmd.r_acc   = 1'b1;
                cmd.r_shift = 1'b1;
                state_next  = S_RLOOP;
            end
            S_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            ret_fin_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_fin_reg <= ret_fin_next;
        end
    end

endmodule

### hw/rtl/tpmq_datapath.sv
module tpmq_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tpmq_pkg::tpmq_cmd_t                   cmd,
    output tpmq_pkg::tpmq_stat_t                  stat,
    input  logic [1:0]                            in_op,
    input  logic [87:0]                           in_data,
    input  logic                                  cfg_we,
    input  logic [tpmq_pkg::NODE_BITS-1:0]        cfg_wdata,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tpmq_pkg::WEIGHT_BITS-1:0]      out_max
);

    localparam int NB = tpmq_pkg::NODE_BITS;
    localparam int WB = tpmq_pkg::WEIGHT_BITS;
    localparam int TB = tpmq_pkg::TIDX_BITS;
    localparam int DB = tpmq_pkg::DEPTH_BITS;

    // memories
    logic [tpmq_pkg::NENT_BITS-1:0] node_mem [0:tpmq_pkg::MAX_NODES-1];
    logic [WB-1:0] tree_mem [0:2*tpmq_pkg::MAX_NODES-1];

    // latched item
    tpmq_pkg::op_t op_reg;
    logic [NB-1:0] na_in_reg, nb_in_reg, pos_in_reg, hd_in_reg, par_in_reg;
    logic [DB-1:0] dp_in_reg;
    logic [WB-1:0] w_in_reg;

    logic [NB-1:0] node_count_reg;
    logic [NB-1:0] in_use;

    // query state
    logic [NB-1:0] qa_reg, qb_reg, ha_reg, hb_reg, pa_reg, pb_reg;
    logic [NB-1:0] posha_reg, parha_reg;
    logic [DB-1:0] dha_reg;
    logic [NB-1:0] steps_reg;
    logic [TB-1:0] lo_reg, hi_reg, ta_reg, tb_reg;
    logic [WB-1:0] res_reg;

    // leaf update
    logic [tpmq_pkg::TADDR_BITS-1:0] idx_reg;
    logic [WB-1:0] cur_reg;
    logic [tpmq_pkg::TADDR_BITS-1:0] clr_reg;

    // memory reads
    logic [tpmq_pkg::NENT_BITS-1:0] nrd_reg;
    logic nzero_reg;
    logic [WB-1:0] trd_reg;

    logic [tpmq_pkg::NENT_BITS-1:0] ndata;
    logic [NB-1:0] nd_pos, nd_head, nd_par;
    logic [DB-1:0] nd_dep;

    logic [NB-1:0] nrd_node;
    logic nrd_en;
    logic [TB-1:0] lo_c, hi_c;
    logic [WB-1:0] up_val, acc_val;

    logic out_valid_reg;
    logic [WB-1:0] out_max_reg;

    assign in_use = (node_count_reg > NB'(tpmq_pkg::MAX_NODES)) ?
                    NB'(tpmq_pkg::MAX_NODES) : node_count_reg;

    assign ndata = nzero_reg ? '0 : nrd_reg;
    assign {nd_pos, nd_head, nd_dep, nd_par} = ndata;

    // clipped range bounds
    assign lo_c = (lo_reg < TB'(1)) ? TB'(1) : lo_reg;
    assign hi_c = (hi_reg > TB'(in_use)) ? TB'(in_use) : hi_reg;

    assign up_val  = (cur_reg > trd_reg) ? cur_reg : trd_reg;
    assign acc_val = (res_reg > trd_reg) ? res_reg : trd_reg;

    always_comb
    begin
        nrd_en   = 1'b1;
        nrd_node = qa_reg;
        priority if (cmd.rd_a)
            nrd_node = qa_reg;
        else if (cmd.rd_b)
            nrd_node = qb_reg;
        else if (cmd.rd_ha)
            nrd_node = ha_reg;
        else if (cmd.rd_hb)
            nrd_node = hb_reg;
        else
            nrd_en = 1'b0;
    end

    assign stat.op         = op_reg;
    assign stat.node_ok    = tpmq_pkg::slot_ok(na_in_reg);
    assign stat.pos_ok     = (pos_in_reg >= NB'(1)) && (pos_in_reg <= in_use);
    assign stat.idx_gt1    = (idx_reg > tpmq_pkg::TADDR_BITS'(1));
    assign stat.same_chain = (ha_reg == hb_reg) ||
                             (steps_reg == NB'(tpmq_pkg::MAX_NODES));
    assign stat.r_empty    = (lo_c > hi_c);
    assign stat.r_lt       = (ta_reg < tb_reg);
    assign stat.ta_odd     = ta_reg[0];
    assign stat.tb_odd     = tb_reg[0];
    assign stat.clr_last   = (clr_reg == '1);
    assign stat.out_busy   = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign out_max   = out_max_reg;

    // node table
    always_ff @(posedge clk)
    begin
        if (cmd.node_wr)
            node_mem[tpmq_pkg::NADDR_BITS'(na_in_reg - NB'(1))] <=
                {pos_in_reg, hd_in_reg, dp_in_reg, par_in_reg};
        if (nrd_en)
        begin
            nrd_reg   <= node_mem[tpmq_pkg::NADDR_BITS'(nrd_node - NB'(1))];
            nzero_reg <= !tpmq_pkg::slot_ok(nrd_node);
        end
    end

    // max tree
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            tree_mem[clr_reg] <= '0;
        else if (cmd.leaf_wr)
            tree_mem[tpmq_pkg::TADDR_BITS'(tpmq_pkg::MAX_NODES) + pos_in_reg - 1'b1]
                <= w_in_reg;
        else if (cmd.up_wr)
            tree_mem[idx_reg >> 1] <= up_val;

        if (cmd.sib_rd)
            trd_reg <= tree_mem[idx_reg ^ tpmq_pkg::TADDR_BITS'(1)];
        else if (cmd.r_rd_a)
            trd_reg <= tree_mem[ta_reg[tpmq_pkg::TADDR_BITS-1:0]];
        else if (cmd.r_rd_b)
            trd_reg <= tree_mem[tpmq_pkg::TADDR_BITS'(tb_reg - TB'(1))];
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NB'(1);
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= tpmq_pkg::OP_NONE;
        end
        else
        begin
            if (cfg_we)
                node_count_reg <= cfg_wdata;
            if (cmd.clr_wr)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.latch)
                op_reg <= tpmq_pkg::op_t'(in_op);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            na_in_reg  <= in_data[10:0];
            nb_in_reg  <= in_data[21:11];
            pos_in_reg <= in_data[32:22];
            hd_in_reg  <= in_data[43:33];
            dp_in_reg  <= in_data[53:44];
            par_in_reg <= in_data[64:54];
            w_in_reg   <= in_data[84:65];
        end
        if (cmd.leaf_wr)
        begin
            idx_reg <= tpmq_pkg::TADDR_BITS'(tpmq_pkg::MAX_NODES) + pos_in_reg - 1'b1;
            cur_reg <= w_in_reg;
        end
        if (cmd.up_wr)
        begin
            idx_reg <= idx_reg >> 1;
            cur_reg <= up_val;
        end
        if (cmd.q_init)
        begin
            qa_reg    <= na_in_reg;
            qb_reg    <= nb_in_reg;
            steps_reg <= '0;
            res_reg   <= '0;
        end
        if (cmd.cap_a)
        begin
            ha_reg <= nd_head;
            pa_reg <= nd_pos;
        end
        if (cmd.cap_b)
        begin
            hb_reg <= nd_head;
            pb_reg <= nd_pos;
        end
        if (cmd.cap_ha)
        begin
            dha_reg   <= nd_dep;
            posha_reg <= nd_pos;
            parha_reg <= nd_par;
        end
        if (cmd.step)
        begin
            // climb the side whose chain head is deeper (a on ties)
            if (dha_reg < nd_dep)
            begin
                lo_reg <= TB'(nd_pos);
                hi_reg <= TB'(pb_reg);
                qa_reg <= nd_par;
                qb_reg <= qa_reg;
            end
            else
            begin
                lo_reg <= TB'(posha_reg);
                hi_reg <= TB'(pa_reg);
                qa_reg <= parha_reg;
            end
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.fin)
        begin
            if (pa_reg > pb_reg)
            begin
                lo_reg <= TB'(pb_reg) + TB'(1);
                hi_reg <= TB'(pa_reg);
            end
            else
            begin
                lo_reg <= TB'(pa_reg) + TB'(1);
                hi_reg <= TB'(pb_reg);
            end
        end
        if (cmd.r_init)
        begin
            ta_reg <= TB'(tpmq_pkg::MAX_NODES) + lo_c - TB'(1);
            tb_reg <= TB'(tpmq_pkg::MAX_NODES) + hi_c;
        end
        if (cmd.r_rd_a)
            ta_reg <= ta_reg + TB'(1);
        if (cmd.r_rd_b)
            tb_reg <= tb_reg - TB'(1);
        if (cmd.r_acc)
            res_reg <= acc_val;
        if (cmd.r_shift)
        begin
            ta_reg <= (cmd.r_rd_a ? ta_reg + TB'(1) : ta_reg) >> 1;
            tb_reg <= tb_reg >> 1;
        end
        if (cmd.out_load)
            out_max_reg <= res_reg;
    end

endmodule

### hw/rtl/tree_path_max_query_unit.sv
// Sequencing: a load item is latched, then written to the node table; a weight
//   item writes its leaf, then a sibling read and parent write per tree level;
//   query items climb chains, range-scanning the max tree. One item at a time.
// The max-tree memory and the node table each have a single read port,
//   walked by the controller one access at a time.
// Reset (rst_n low, async): node_count = 1, result register empty, then a
//   pass zeroes all 2048 max-tree entries; s_axis_tready stays low meanwhile.
module tree_path_max_query_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: node_a[11], node_b[11], position[11], chain_head[11],
    // node_depth[10], parent_node[11], weight[20], zero pad[3]
    input  logic [87:0] s_axis_tdata,
    // tuser: op[2]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: path_max[20], zero pad[4]
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    tpmq_pkg::tpmq_cmd_t  cmd;
    tpmq_pkg::tpmq_stat_t stat;
    logic [tpmq_pkg::WEIGHT_BITS-1:0] path_max;

    // controller: sequencing of load, leaf update, chain climb, range scan
    tpmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: node table, max tree, query registers, result register
    tpmq_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_max   (path_max)
    );

    assign m_axis_tdata = {4'b0, path_max};

endmodule
